### design/assert_macros.svh
// Assertion macros for the checker file of the sorted insert table.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIT_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIT_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/sit_pkg.sv
// Shared types and constants for the sorted insert table.
// No dependencies; the top module and the checker import this package.
`default_nettype none

package sit_pkg;

    localparam int KEY_WIDTH           = 32;
    localparam int PAYLOAD_FIELD_WIDTH = 16;
    localparam int INDEX_WIDTH         = 6;
    localparam int POSITION_WIDTH      = 6;
    localparam int FILL_WIDTH          = 7;

    localparam int DEF_TABLE_DEPTH   = 64;
    localparam int DEF_PAYLOAD_WIDTH = 16;

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_READ   = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed
    {
        action_t                        action;
        logic [KEY_WIDTH-1:0]           key;
        logic [PAYLOAD_FIELD_WIDTH-1:0] payload;
        logic [INDEX_WIDTH-1:0]         index;
    } sit_req_t;

    typedef struct packed
    {
        logic [POSITION_WIDTH-1:0]      position;
        logic [KEY_WIDTH-1:0]           entry_key;
        logic [PAYLOAD_FIELD_WIDTH-1:0] entry_payload;
        logic [FILL_WIDTH-1:0]          fill;
        status_t                        status;
    } sit_rsp_t;

endpackage

`default_nettype wire

### design/sit_stream_if.sv
// Valid/ready channel carrying one request or response per handshake.
// The payload type is a parameter; the sorted insert table uses the sit_pkg structs.
`default_nettype none

interface sit_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

### design/sit_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module sit_ram
#(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### design/sorted_insert_table_top.sv
// Sorted insert table: entries kept in ascending key order in one RAM (sit_pkg, sit_ram).
// Flow: an accepted full insert, insert into an empty table or out-of-range read goes from S_IDLE
// straight to S_FINISH; an in-range read passes S_READ, and an insert into a non-empty table passes
// S_SCAN, which moves every larger entry up, and S_PLACE if all entries moved. S_FINISH registers the
// response. A new request is taken only in S_IDLE, after the last response has left S_FINISH.
// A finished response may wait on rsp. Reset (rst_n, async): empty.
`default_nettype none

module sorted_insert_table_top
    import sit_pkg::*;
#(
    parameter int TABLE_DEPTH   = DEF_TABLE_DEPTH,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    sit_stream_if.sink   req,
    sit_stream_if.source rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;
    localparam int EW = KEY_WIDTH + PAYLOAD_WIDTH;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_PLACE,
        S_FINISH
    } state_t;

    state_t                   state_reg;
    logic [CW-1:0]            count_reg;
    logic [AW-1:0]            scan_reg;
    logic [KEY_WIDTH-1:0]     key_reg;
    logic [PAYLOAD_WIDTH-1:0] payload_reg;
    sit_rsp_t                 result_reg;
    logic                     out_valid_reg;
    sit_rsp_t                 out_data_reg;
    sit_rsp_t                 finish_rsp;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [EW-1:0]            ram_rdata;

    logic [KEY_WIDTH-1:0]     rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_payload;
    logic [PAYLOAD_WIDTH-1:0] req_payload;
    logic                     table_full;
    logic                     table_empty;
    logic                     index_valid;
    logic                     key_gt;

    sit_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_sit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key      = ram_rdata[EW-1:PAYLOAD_WIDTH];
    assign rd_payload  = ram_rdata[PAYLOAD_WIDTH-1:0];
    assign req_payload = PAYLOAD_WIDTH'(req.data.payload);
    assign table_full  = (count_reg == CW'(TABLE_DEPTH));
    assign table_empty = (count_reg == '0);
    assign index_valid = (IW'(req.data.index) < IW'(count_reg));

    // The shared key comparator: the entry just read against the key being inserted.
    assign key_gt = (rd_key > key_reg);

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

    // The fill count is taken when the response leaves, after the table has been updated.
    always_comb
    begin
        finish_rsp      = result_reg;
        finish_rsp.fill = FILL_WIDTH'(count_reg);
    end

    // RAM port control. The scan walks down from the last entry; every entry whose key is larger moves
    // up by one, and the new entry goes above the first that is not larger, or to address 0 (S_PLACE).
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = scan_reg + AW'(1);
        ram_wdata = {key_reg, payload_reg};
        ram_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.action == ACT_READ)
                    begin
                        ram_raddr = AW'(req.data.index);
                    end
                    else if (table_empty)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = {req.data.key, req_payload};
                    end
                    else
                    begin
                        ram_raddr = AW'(count_reg - CW'(1));
                    end
                end
            end
            S_SCAN:
            begin
                ram_we    = 1'b1;
                ram_raddr = scan_reg - AW'(1);
                ram_wdata = key_gt ? ram_rdata : {key_reg, payload_reg};
            end
            S_PLACE:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            key_reg       <= '0;
            payload_reg   <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (state_reg == S_FINISH && (!out_valid_reg || rsp.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        key_reg     <= req.data.key;
                        payload_reg <= req_payload;
                        if (req.data.action == ACT_READ)
                        begin
                            result_reg.position <= req.data.index;
                            if (index_valid)
                            begin
                                result_reg.status <= ST_OK;
                                state_reg         <= S_READ;
                            end
                            else
                            begin
                                result_reg.entry_key     <= '0;
                                result_reg.entry_payload <= '0;
                                result_reg.status        <= ST_RANGE;
                                state_reg                <= S_FINISH;
                            end
                        end
                        else
                        begin
                            result_reg.entry_key     <= req.data.key;
                            result_reg.entry_payload <= PAYLOAD_FIELD_WIDTH'(req_payload);
                            if (table_full)
                            begin
                                result_reg.position <= '0;
                                result_reg.status   <= ST_FULL;
                                state_reg           <= S_FINISH;
                            end
                            else if (table_empty)
                            begin
                                result_reg.position <= '0;
                                result_reg.status   <= ST_OK;
                                count_reg           <= count_reg + CW'(1);
                                state_reg           <= S_FINISH;
                            end
                            else
                            begin
                                result_reg.status <= ST_OK;
                                scan_reg          <= AW'(count_reg - CW'(1));
                                state_reg         <= S_SCAN;
                            end
                        end
                    end
                end
                S_READ:
                begin
                    result_reg.entry_key     <= rd_key;
                    result_reg.entry_payload <= PAYLOAD_FIELD_WIDTH'(rd_payload);
                    state_reg                <= S_FINISH;
                end
                S_SCAN:
                begin
                    if (key_gt)
                    begin
                        if (scan_reg == '0)
                        begin
                            state_reg <= S_PLACE;
                        end
                        else
                        begin
                            scan_reg <= scan_reg - AW'(1);
                        end
                    end
                    else
                    begin
                        result_reg.position <= POSITION_WIDTH'(scan_reg + AW'(1));
                        count_reg           <= count_reg + CW'(1);
                        state_reg           <= S_FINISH;
                    end
                end
                S_PLACE:
                begin
                    result_reg.position <= '0;
                    count_reg           <= count_reg + CW'(1);
                    state_reg           <= S_FINISH;
                end
                S_FINISH:
                begin
                    // Hand the result to the output register once it is free.
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_data_reg <= finish_rsp;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### design/sit_checker.sv
// Port-level assertions for the sorted insert table, bound to sorted_insert_table_top.
// Depends on sit_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sit_checker
    import sit_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input sit_rsp_t rsp_data
);

    // A pending response is not withdrawn.
    `SIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

    // The table works on one request at a time.
    `SIT_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "request taken while busy")

    `SIT_ASSERT(a_range_zero, rsp_valid && rsp_data.status == ST_RANGE, rsp_data.entry_key == '0 && rsp_data.entry_payload == '0, "out-of-range read returned data")

    `SIT_ASSERT(a_full_position, rsp_valid && rsp_data.status == ST_FULL, rsp_data.position == '0, "dropped insert reported a position")

endmodule

bind sorted_insert_table_top sit_checker u_sit_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
